// ===== sv/jpeg_exif_segment_extractor_top_macros.svh =====
// assertion helpers for the exif segment extractor
`ifndef JPEG_EXIF_SEGMENT_EXTRACTOR_TOP_MACROS_SVH
`define JPEG_EXIF_SEGMENT_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define JESX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define JESX_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/jesx_pkg.sv =====
package jesx_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   localparam logic [1:0] STATUS_SEG       = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // work codes handed from the parser to the result generator
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_BYTE  = 3'd1;
   localparam logic [2:0] CMD_FAIL  = 3'd2;
   localparam logic [2:0] CMD_TRUNC = 3'd3;
   localparam logic [2:0] CMD_BURST = 3'd4;

   localparam logic [7:0] MARK_FILL = 8'hFF;
   localparam logic [7:0] MARK_SOI  = 8'hD8;
   localparam logic [7:0] MARK_EOI  = 8'hD9;
   localparam logic [7:0] MARK_SOS  = 8'hDA;
   localparam logic [7:0] MARK_APP1 = 8'hE1;

   localparam int SIG_LEN   = 6;
   localparam int BURST_LEN = 10;

   typedef struct packed {
      logic        pre_trunc;
      logic [2:0]  kind;
      logic [7:0]  byte_val;
      logic [15:0] length_word;
      logic        last;
   } cmd_type;

   function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h45;
         3'd1:    val = 8'h78;
         3'd2:    val = 8'h69;
         3'd3:    val = 8'h66;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/jpeg_exif_segment_extractor_top.sv =====
// Exif APP1 extractor: takes one JPEG file byte per cycle and returns the Exif segment byte
// by byte, or one status word when no segment is found or a segment is cut short. The parser
// takes a byte in every cycle that its work queue (CMD_DEPTH entries) has room; the result
// side delivers one result per cycle while results are popped, so a confirmed signature,
// which yields ten results at once, drains from the queue while the parser keeps taking
// bytes until the queue fills. When nothing is queued ahead, a result passes through the
// work queue and then the output register before it reaches the result ports.
`include "jpeg_exif_segment_extractor_top_macros.svh"

module jpeg_exif_segment_extractor_top
   import jesx_pkg::*;
#(
   parameter int CMD_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   logic    head_valid;
   cmd_type head;
   logic    head_pop;

   assign accept = req_push && !req_full;

   jesx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   jesx_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   jesx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   `JESX_ASSERT_NOW(a_status_code, clock, reset, !rsp_empty, rsp_data.status != 2'd3, "bad status code")
   `JESX_ASSERT_NOW(a_status_form, clock, reset, !rsp_empty && rsp_data.status != STATUS_SEG, rsp_data.last && rsp_data.out_byte == 8'h00, "status result not final or not zero")
   `JESX_ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty, "results pending after reset")

endmodule

// ===== sv/jesx_front.sv =====
module jesx_front
   import jesx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type item,
   output logic    cmd_push,
   output cmd_type cmd
);

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_SOI1 = 4'd1;
   localparam logic [3:0] PH_SOI2 = 4'd2;
   localparam logic [3:0] PH_HUNT = 4'd3;
   localparam logic [3:0] PH_MARK = 4'd4;
   localparam logic [3:0] PH_LENH = 4'd5;
   localparam logic [3:0] PH_LENL = 4'd6;
   localparam logic [3:0] PH_SKIP = 4'd7;
   localparam logic [3:0] PH_SIG  = 4'd8;
   localparam logic [3:0] PH_EMIT = 4'd9;
   localparam logic [3:0] PH_DONE = 4'd10;

   logic [3:0]  phase_ff, phase_in, phase_eff;
   logic [15:0] length_ff, length_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [7:0]  marker_ff, marker_in;
   logic [2:0]  sig_ff, sig_in;
   logic [15:0] bl_dec, lw_full, lw_m2;
   logic [7:0]  b;
   logic        pre;
   logic [2:0]  kind;
   logic        last;

   assign b       = item.data_byte;
   assign bl_dec  = bytes_ff - 16'd1;
   assign lw_full = {length_ff[15:8], b};
   assign lw_m2   = lw_full - 16'd2;

   always_comb begin
      phase_eff = item.file_start ? PH_SOI1 : phase_ff;
      pre       = item.file_start && (phase_ff == PH_EMIT);
      phase_in  = phase_eff;
      length_in = length_ff;
      bytes_in  = bytes_ff;
      marker_in = marker_ff;
      sig_in    = sig_ff;
      kind      = CMD_NONE;
      last      = 1'b0;
      if (item.stream_end) begin
         if (phase_eff == PH_EMIT) begin
            kind = CMD_TRUNC;
         end else if (phase_eff != PH_IDLE && phase_eff != PH_DONE) begin
            kind = CMD_FAIL;
         end
         phase_in = (phase_eff == PH_IDLE) ? PH_IDLE : PH_DONE;
      end else begin
         unique case (phase_eff)
            PH_SOI1: begin
               if (b == MARK_FILL) phase_in = PH_SOI2;
               else begin
                  kind     = CMD_FAIL;
                  phase_in = PH_DONE;
               end
            end
            PH_SOI2: begin
               if (b == MARK_SOI) phase_in = PH_HUNT;
               else begin
                  kind     = CMD_FAIL;
                  phase_in = PH_DONE;
               end
            end
            PH_HUNT: begin
               if (b == MARK_FILL) phase_in = PH_MARK;
            end
            PH_MARK: begin
               priority if (b == MARK_FILL) begin
                  phase_in = PH_MARK;
               end else if (b == MARK_SOI) begin
                  phase_in = PH_HUNT;
               end else if (b == MARK_EOI || b == MARK_SOS) begin
                  kind     = CMD_FAIL;
                  phase_in = PH_DONE;
               end else begin
                  marker_in = b;
                  phase_in  = PH_LENH;
               end
            end
            PH_LENH: begin
               length_in = {b, 8'h00};
               phase_in  = PH_LENL;
            end
            PH_LENL: begin
               length_in = lw_full;
               if (lw_full < 16'd2) begin
                  kind     = CMD_FAIL;
                  phase_in = PH_DONE;
               end else begin
                  bytes_in = lw_m2;
                  sig_in   = 3'd0;
                  priority if (lw_m2 == 16'd0) phase_in = PH_HUNT;
                  else if (marker_ff == MARK_APP1 && lw_m2 >= 16'(SIG_LEN)) phase_in = PH_SIG;
                  else phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               bytes_in = bl_dec;
               if (bl_dec == 16'd0) phase_in = PH_HUNT;
            end
            PH_SIG: begin
               bytes_in = bl_dec;
               if (b != exif_sig_byte(sig_ff)) begin
                  phase_in = (bl_dec == 16'd0) ? PH_HUNT : PH_SKIP;
               end else begin
                  sig_in = sig_ff + 3'd1;
                  if (sig_ff == 3'(SIG_LEN - 1)) begin
                     kind     = CMD_BURST;
                     last     = (bl_dec == 16'd0);
                     phase_in = (bl_dec == 16'd0) ? PH_DONE : PH_EMIT;
                  end
               end
            end
            PH_EMIT: begin
               bytes_in = bl_dec;
               kind     = CMD_BYTE;
               last     = (bl_dec == 16'd0);
               if (bl_dec == 16'd0) phase_in = PH_DONE;
            end
            default: begin
               phase_in = phase_eff;
            end
         endcase
      end
   end

   assign cmd_push        = accept && (pre || kind != CMD_NONE);
   assign cmd.pre_trunc   = pre;
   assign cmd.kind        = kind;
   assign cmd.byte_val    = b;
   assign cmd.length_word = length_ff;
   assign cmd.last        = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         length_ff <= '0;
         bytes_ff  <= '0;
         marker_ff <= '0;
         sig_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         bytes_ff  <= bytes_in;
         marker_ff <= marker_in;
         sig_ff    <= sig_in;
      end
   end

endmodule

// ===== sv/jesx_cmd_fifo.sv =====
module jesx_cmd_fifo
   import jesx_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/jesx_back.sv =====
module jesx_back
   import jesx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head,
   output logic    head_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [3:0] sub_ff, sub_in;
   logic [3:0] idx;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in, gen;
   logic       done;
   logic       load;
   logic       taken;

   assign idx = sub_ff - {3'b000, head.pre_trunc};

   // result for the current step of the head command
   always_comb begin
      gen  = '{out_byte: 8'h00, last: 1'b1, status: STATUS_NOT_FOUND};
      done = 1'b1;
      if (head.pre_trunc && sub_ff == 4'd0) begin
         gen.status = STATUS_TRUNCATED;
         done       = (head.kind == CMD_NONE);
      end else begin
         unique case (head.kind)
            CMD_BYTE: begin
               gen = '{out_byte: head.byte_val, last: head.last, status: STATUS_SEG};
            end
            CMD_FAIL: begin
               gen.status = STATUS_NOT_FOUND;
            end
            CMD_TRUNC: begin
               gen.status = STATUS_TRUNCATED;
            end
            CMD_BURST: begin
               gen.status = STATUS_SEG;
               gen.last   = head.last && (idx == 4'(BURST_LEN - 1));
               done       = (idx == 4'(BURST_LEN - 1));
               unique case (idx)
                  4'd0:    gen.out_byte = MARK_FILL;
                  4'd1:    gen.out_byte = MARK_APP1;
                  4'd2:    gen.out_byte = head.length_word[15:8];
                  4'd3:    gen.out_byte = head.length_word[7:0];
                  default: gen.out_byte = exif_sig_byte(3'(idx - 4'd4));
               endcase
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   assign taken    = rsp_pop && valid_ff;
   assign load     = head_valid && (!valid_ff || taken);
   assign head_pop = load && done;

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         out_in   = gen;
         valid_in = 1'b1;
         sub_in   = done ? 4'd0 : sub_ff + 4'd1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sim/tb.sv =====
module tb;
   import jesx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      P_IDLE, P_SOI1, P_SOI2, P_HUNT, P_MARK, P_LENH, P_LENL, P_SKIP, P_SIG, P_EMIT, P_DONE
   } parse_phase_e;

   localparam logic [7:0] EXIF_ID [SIG_LEN] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int fail_count = 0;

   rsp_type    expected_rsp [$];
   rsp_type    want;
   logic [7:0] file_buf [$];

   // parser state mirrored for prediction
   parse_phase_e ph = P_IDLE;
   logic [15:0]  seg_len = '0;
   logic [15:0]  remaining = '0;
   logic [7:0]   marker = '0;
   logic [2:0]   sig_count = '0;

   jpeg_exif_segment_extractor_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("jpeg_exif_segment_extractor_top test failed");
      $finish;
   end

   function automatic void append_file_byte(input logic [7:0] b);
      file_buf = {file_buf, b};
   endfunction

   function automatic void add_expected(input logic [7:0] b, input logic lst,
                                        input logic [1:0] st);
      rsp_type r;
      r.out_byte = b;
      r.last = lst;
      r.status = st;
      expected_rsp = {expected_rsp, r};
   endfunction

   function automatic void predict_segment(input req_type it);
      logic [7:0] b;
      b = it.data_byte;
      if (it.file_start) begin
         if (ph == P_EMIT) add_expected(8'h00, 1'b1, STATUS_TRUNCATED);
         ph = P_SOI1;
         seg_len = '0;
         remaining = '0;
         marker = '0;
         sig_count = '0;
      end
      if (it.stream_end) begin
         if (ph == P_EMIT) add_expected(8'h00, 1'b1, STATUS_TRUNCATED);
         else if (ph != P_IDLE && ph != P_DONE) add_expected(8'h00, 1'b1, STATUS_NOT_FOUND);
         if (ph != P_IDLE) ph = P_DONE;
         return;
      end
      case (ph)
         P_SOI1: begin
            if (b == MARK_FILL) ph = P_SOI2;
            else begin
               add_expected(8'h00, 1'b1, STATUS_NOT_FOUND);
               ph = P_DONE;
            end
         end
         P_SOI2: begin
            if (b == MARK_SOI) ph = P_HUNT;
            else begin
               add_expected(8'h00, 1'b1, STATUS_NOT_FOUND);
               ph = P_DONE;
            end
         end
         P_HUNT: begin
            if (b == MARK_FILL) ph = P_MARK;
         end
         P_MARK: begin
            if (b == MARK_SOI) ph = P_HUNT;
            else if (b == MARK_EOI || b == MARK_SOS) begin
               add_expected(8'h00, 1'b1, STATUS_NOT_FOUND);
               ph = P_DONE;
            end else if (b != MARK_FILL) begin
               marker = b;
               ph = P_LENH;
            end
         end
         P_LENH: begin
            seg_len = {b, 8'h00};
            ph = P_LENL;
         end
         P_LENL: begin
            seg_len[7:0] = b;
            if (seg_len < 16'd2) begin
               add_expected(8'h00, 1'b1, STATUS_NOT_FOUND);
               ph = P_DONE;
            end else begin
               remaining = seg_len - 16'd2;
               sig_count = '0;
               if (remaining == 16'd0) ph = P_HUNT;
               else if (marker == MARK_APP1 && remaining >= 16'd6) ph = P_SIG;
               else ph = P_SKIP;
            end
         end
         P_SKIP: begin
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) ph = P_HUNT;
         end
         P_SIG: begin
            remaining = remaining - 16'd1;
            if (b != EXIF_ID[sig_count]) begin
               ph = (remaining == 16'd0) ? P_HUNT : P_SKIP;
            end else begin
               sig_count = sig_count + 3'd1;
               if (sig_count == SIG_LEN) begin
                  // signature confirmed: replay the segment header in one burst
                  add_expected(MARK_FILL, 1'b0, STATUS_SEG);
                  add_expected(MARK_APP1, 1'b0, STATUS_SEG);
                  add_expected(seg_len[15:8], 1'b0, STATUS_SEG);
                  add_expected(seg_len[7:0], 1'b0, STATUS_SEG);
                  for (int i = 0; i < SIG_LEN; i++)
                     add_expected(EXIF_ID[i], (i == SIG_LEN - 1) && (remaining == 16'd0),
                                  STATUS_SEG);
                  ph = (remaining == 16'd0) ? P_DONE : P_EMIT;
               end
            end
         end
         P_EMIT: begin
            remaining = remaining - 16'd1;
            add_expected(b, remaining == 16'd0, STATUS_SEG);
            if (remaining == 16'd0) ph = P_DONE;
         end
         default: ;
      endcase
   endfunction

   // result checker: the transfer is decided by values that are stable at the falling edge
   always @(negedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsp.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result: byte %02h last %0b status %0d",
                        rsp_data.out_byte, rsp_data.last, rsp_data.status);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last ||
                rsp_data.status !== want.status) begin
               if (fail_count < 10)
                  $display("mismatch: expected byte %02h last %0b status %0d, got %02h %0b %0d",
                           want.out_byte, want.last, want.status,
                           rsp_data.out_byte, rsp_data.last, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   task automatic send_item(input logic [7:0] b, input logic st, input logic fin);
      req_type it;
      it.data_byte = b;
      it.file_start = st;
      it.stream_end = fin;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      forever begin
         @(negedge clock);
         if (!req_full) break;
         @(posedge clock);
      end
      predict_segment(it);
      @(posedge clock);
   endtask

   task automatic send_file(input bit close_stream);
      for (int i = 0; i < file_buf.size(); i++)
         send_item(file_buf[i], i == 0, 1'b0);
      if (close_stream) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic wait_for_results();
      req_push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic void build_random_file(output bit close_stream);
      int n_seg;
      int kind;
      int plen;
      logic [7:0] mk;
      logic [15:0] len;
      file_buf.delete();
      close_stream = $urandom_range(0, 1);
      if ($urandom_range(0, 7) == 0) begin
         // noise, sometimes behind a valid start of image
         if ($urandom_range(0, 1)) begin
            append_file_byte(MARK_FILL);
            append_file_byte(MARK_SOI);
         end
         repeat ($urandom_range(1, 16)) append_file_byte(8'($urandom_range(0, 255)));
         return;
      end
      append_file_byte(MARK_FILL);
      append_file_byte(MARK_SOI);
      n_seg = $urandom_range(1, 3);
      for (int s = 0; s < n_seg; s++) begin
         repeat ($urandom_range(0, 2)) append_file_byte(8'($urandom_range(0, 254)));
         append_file_byte(MARK_FILL);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) append_file_byte(MARK_FILL);
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            append_file_byte(MARK_APP1);
            if ($urandom_range(0, 4) == 0) begin
               // long segment that gets cut off after a few bytes
               len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
               plen = SIG_LEN + $urandom_range(0, 4);
            end else begin
               plen = SIG_LEN + $urandom_range(0, 6);
               len = 16'(plen + 2);
            end
            append_file_byte(len[15:8]);
            append_file_byte(len[7:0]);
            for (int i = 0; i < plen; i++)
               append_file_byte(i < SIG_LEN ? EXIF_ID[i] : 8'($urandom_range(0, 255)));
            return;
         end else if (kind < 50) begin
            // app1 that is too short or carries a broken signature
            plen = $urandom_range(0, 9);
            append_file_byte(MARK_APP1);
            append_file_byte(8'h00);
            append_file_byte(8'(plen + 2));
            mk = 8'($urandom_range(1, 255));
            len = 16'($urandom_range(0, (plen < SIG_LEN ? plen : SIG_LEN) - 1));
            for (int i = 0; i < plen; i++) begin
               if (i >= SIG_LEN) append_file_byte(8'($urandom_range(0, 255)));
               else if (i == len && (plen >= SIG_LEN || mk[0])) append_file_byte(EXIF_ID[i] ^ mk);
               else append_file_byte(EXIF_ID[i]);
            end
         end else if (kind < 85) begin
            do mk = 8'($urandom_range(0, 255));
            while (mk == MARK_FILL || mk == MARK_SOI || mk == MARK_EOI || mk == MARK_SOS);
            append_file_byte(mk);
            if ($urandom_range(0, 9) == 0) begin
               append_file_byte(8'($urandom_range(1, 255)));
               append_file_byte(8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, 5)) append_file_byte(8'($urandom_range(0, 255)));
               return;
            end
            plen = $urandom_range(0, 10);
            append_file_byte(8'h00);
            append_file_byte(8'(plen + 2));
            repeat (plen) append_file_byte(8'($urandom_range(0, 255)));
         end else if (kind < 92) begin
            append_file_byte(MARK_SOI);
         end else begin
            append_file_byte(8'hC4);
            append_file_byte(8'h00);
            append_file_byte(8'($urandom_range(0, 1)));
            return;
         end
      end
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
         append_file_byte(MARK_FILL);
         append_file_byte(MARK_EOI);
      end else if (kind == 1) begin
         append_file_byte(MARK_FILL);
         append_file_byte(MARK_SOS);
      end
   endfunction

   task automatic test_outside_file();
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h3C, 1'b0, 1'b1);
   endtask

   task automatic test_bad_start();
      // bytes after the failed search and the closing transfer are ignored
      file_buf = '{8'h00, MARK_FILL, MARK_SOI};
      send_file(1'b1);
      file_buf = '{MARK_FILL, 8'hD7};
      send_file(1'b0);
      send_item(MARK_FILL, 1'b1, 1'b1);
   endtask

   task automatic test_search_end();
      file_buf = '{MARK_FILL, MARK_SOI, 8'h12, MARK_FILL, MARK_FILL, MARK_SOI,
                   MARK_FILL, MARK_EOI};
      send_file(1'b0);
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, MARK_SOS};
      send_file(1'b0);
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, 8'hC0, 8'h00, 8'h01};
      send_file(1'b0);
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, 8'hDB, 8'h00, 8'h03, 8'h77};
      send_file(1'b1);
   endtask

   task automatic test_exif_extract();
      // zero-length app1, short app1, wrong signature, then a bare signature
      file_buf = '{MARK_FILL, MARK_SOI,
                   MARK_FILL, MARK_APP1, 8'h00, 8'h02,
                   MARK_FILL, MARK_APP1, 8'h00, 8'h07, 8'h45, 8'h78, 8'h69, 8'h66, 8'h00,
                   MARK_FILL, MARK_APP1, 8'h00, 8'h08, 8'h45, 8'h78, 8'h69, 8'h67, 8'h00, 8'h00,
                   MARK_FILL, MARK_APP1, 8'h00, 8'h08, 8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
      send_file(1'b1);
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, MARK_APP1, 8'h00, 8'h0A,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'hFF};
      send_file(1'b0);
   endtask

   task automatic test_truncation();
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, MARK_APP1, 8'h01, 8'h00,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h80};
      send_file(1'b1);
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, MARK_APP1, 8'hFF, 8'hFF,
                   8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00, 8'h7F};
      send_file(1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      // search still in the signature when the next file starts
      file_buf = '{MARK_FILL, MARK_SOI, MARK_FILL, MARK_APP1, 8'h00, 8'h10, 8'h45};
      send_file(1'b0);
   endtask

   task automatic test_random_files(input int n_items);
      int sent;
      bit close_stream;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            sent++;
         end else begin
            build_random_file(close_stream);
            send_file(close_stream);
            sent += file_buf.size() + int'(close_stream);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 7;
      rx_idle_pct = 79;
      test_outside_file();
      test_bad_start();
      test_search_end();
      test_exif_extract();
      test_truncation();
      wait_for_results();
      test_random_files(40);
      wait_for_results();

      tx_idle_pct = 79;
      rx_idle_pct = 7;
      test_random_files(35);
      wait_for_results();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_files(35);
      wait_for_results();

      if (fail_count == 0) $display("jpeg_exif_segment_extractor_top test passed");
      else $display("jpeg_exif_segment_extractor_top test failed");
      $finish;
   end

endmodule

// ===== jpeg_exif_segment_extractor_top.f =====
+incdir+sv
sv/jesx_pkg.sv
sv/jesx_front.sv
sv/jesx_cmd_fifo.sv
sv/jesx_back.sv
sv/jpeg_exif_segment_extractor_top.sv
sim/tb.sv
